// ===== src/hnm_pkg.sv =====
package hnm_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int COORD_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W      = COORD_W + 1;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int HEIGHT_W    = 16;
    localparam int STRENGTH_W  = 12;
    localparam int CODE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [SIDE_W-1:0]     SIDE_MIN       = SIDE_W'(2);
    localparam logic [SIDE_W-1:0]     SIDE_MAX       = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0]     SIDE_RESET     = SIDE_W'(64);
    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = STRENGTH_W'(1536);

    // arithmetic widths
    localparam int DIFF_W     = HEIGHT_W + 1;
    localparam int PROD_W     = DIFF_W + STRENGTH_W + 1;
    localparam int MAG_W      = PROD_W - 2;
    localparam int SQ_W       = 2 * MAG_W + 2;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int NUM_W      = 40;
    localparam int Q_STEPS    = 9;
    localparam int Q_W        = Q_STEPS;

    localparam logic [SQ_W-1:0]          LEN_BIAS = SQ_W'(1) << 44;
    localparam logic signed [PROD_W-1:0] ONE_Q22  = PROD_W'(1) << 22;
    localparam logic [Q_W-1:0]           CODE_MAX = Q_W'(255);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int OUT_DEPTH   = 16;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = OPTR_W + 1;

    localparam int NB_COUNT = 4;
    localparam int NB_W     = $clog2(NB_COUNT);
    localparam logic [NB_W-1:0] NB_XN = NB_W'(0);
    localparam logic [NB_W-1:0] NB_XP = NB_W'(1);
    localparam logic [NB_W-1:0] NB_YN = NB_W'(2);
    localparam logic [NB_W-1:0] NB_YP = NB_W'(3);

    typedef enum logic {
        REQ_STORE = 1'b0,
        REQ_READ  = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_SIDE     = 2'd0,
        CFG_BUMP_STRENGTH = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        t_req                               req;
        logic [NB_COUNT-1:0][ADDR_W-1:0]    addr;
        logic [HEIGHT_W-1:0]                height;
    } t_cmd;

    typedef struct packed {
        logic [CODE_W-1:0] x;
        logic [CODE_W-1:0] y;
        logic [CODE_W-1:0] z;
    } t_normal;

endpackage

// ===== src/height_to_normal_map.sv =====
// Height tile to normal map. Store requests write one signed Q1.14 height into
// the 64x64 tile memory; read requests fetch the four wrapped neighbours from
// the single-port tile memory, one per cycle, and no new request is taken until
// that fetch is done. Stores are taken at one per cycle while no read is
// fetching. Each read yields one encoded normal (multiply, squares, a 29-stage
// square root and a 9-stage divider, all fully pipelined); up to 16 reads may
// be outstanding before the block holds off further reads. The tile has no
// reset and no clearing pass: read only texels already written. Configuration
// writes are always accepted and should be made while idle.
module height_to_normal_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_req_type,
    input  logic [hnm_pkg::COORD_W-1:0]       i_texel_x,
    input  logic [hnm_pkg::COORD_W-1:0]       i_texel_y,
    input  logic signed [hnm_pkg::HEIGHT_W-1:0] i_height_sample,
    output logic                              empty,
    input  logic                              pop,
    output logic [hnm_pkg::CODE_W-1:0]        o_normal_x_code,
    output logic [hnm_pkg::CODE_W-1:0]        o_normal_y_code,
    output logic [hnm_pkg::CODE_W-1:0]        o_normal_z_code,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hnm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hnm_pkg::*;

    logic [SIDE_W-1:0]     r_tile_side;
    logic [STRENGTH_W-1:0] r_bump_strength;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_side     <= SIDE_RESET;
            r_bump_strength <= STRENGTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TILE_SIDE:     r_tile_side     <= i_cfg_data[SIDE_W-1:0];
                CFG_BUMP_STRENGTH: r_bump_strength <= i_cfg_data[STRENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    t_cmd  f_cmd, q_cmd;
    logic  f_valid, f_ready, q_valid, q_ready;
    logic  d_valid;
    logic signed [DIFF_W-1:0] du, dv;
    t_normal normal;

    hnm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_req_type      (t_req'(i_req_type)),
        .i_texel_x       (i_texel_x),
        .i_texel_y       (i_texel_y),
        .i_height_sample (i_height_sample),
        .i_tile_side     (r_tile_side),
        .o_cmd           (f_cmd),
        .o_cmd_valid     (f_valid),
        .i_cmd_ready     (f_ready)
    );

    hnm_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (f_cmd),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .o_cmd   (q_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready)
    );

    hnm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_out_pop   (pop && !empty),
        .o_d_valid   (d_valid),
        .o_du        (du),
        .o_dv        (dv)
    );

    hnm_math u_math (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (d_valid),
        .i_du       (du),
        .i_dv       (dv),
        .i_strength (r_bump_strength),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_normal   (normal)
    );

    assign o_normal_x_code = normal.x;
    assign o_normal_y_code = normal.y;
    assign o_normal_z_code = normal.z;

endmodule

// ===== src/hnm_front.sv =====
module hnm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  hnm_pkg::t_req                 i_req_type,
    input  logic [hnm_pkg::COORD_W-1:0]   i_texel_x,
    input  logic [hnm_pkg::COORD_W-1:0]   i_texel_y,
    input  logic [hnm_pkg::HEIGHT_W-1:0]  i_height_sample,
    input  logic [hnm_pkg::SIDE_W-1:0]    i_tile_side,
    output hnm_pkg::t_cmd                 o_cmd,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready
);
    import hnm_pkg::*;

    logic [SIDE_W-1:0]  side;
    logic [SIDE_W-1:0]  last_w;
    logic [COORD_W-1:0] last;
    logic [COORD_W-1:0] x, y, xp, xn, yp, yn;
    logic               accept;
    t_cmd               n_cmd;
    t_cmd               r_cmd;
    logic               r_v;

    always_comb begin
        side = i_tile_side;
        if (side < SIDE_MIN) begin
            side = SIDE_MIN;
        end
        if (side > SIDE_MAX) begin
            side = SIDE_MAX;
        end
        last_w = side - SIDE_W'(1);
        last   = last_w[COORD_W-1:0];
        x  = (i_texel_x > last) ? last : i_texel_x;
        y  = (i_texel_y > last) ? last : i_texel_y;
        xp = (x == '0) ? last : x - COORD_W'(1);
        xn = (x == last) ? '0 : x + COORD_W'(1);
        yp = (y == '0) ? last : y - COORD_W'(1);
        yn = (y == last) ? '0 : y + COORD_W'(1);
        n_cmd.req    = i_req_type;
        n_cmd.height = i_height_sample;
        n_cmd.addr   = '0;
        if (i_req_type == REQ_STORE) begin
            n_cmd.addr[NB_XN] = {y, x};
        end else begin
            n_cmd.addr[NB_XN] = {y, xn};
            n_cmd.addr[NB_XP] = {y, xp};
            n_cmd.addr[NB_YN] = {yn, x};
            n_cmd.addr[NB_YP] = {yp, x};
        end
    end

    assign full        = r_v && !i_cmd_ready;
    assign accept      = push && !full;
    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (i_cmd_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== src/hnm_cmd_queue.sv =====
module hnm_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hnm_pkg::t_cmd i_cmd,
    input  logic          i_valid,
    output logic          o_ready,
    output hnm_pkg::t_cmd o_cmd,
    output logic          o_valid,
    input  logic          i_ready
);
    import hnm_pkg::*;

    t_cmd              r_q [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              wr_en, rd_en;

    assign o_ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_q[r_rd];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (rd_en) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(wr_en) - QCNT_W'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= i_cmd;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == QCNT_W'(QUEUE_DEPTH) |=> r_cnt == QCNT_W'(QUEUE_DEPTH) || $past(rd_en))
        else $error("command queue overrun");

endmodule

// ===== src/hnm_back.sv =====
module hnm_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hnm_pkg::t_cmd                   i_cmd,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  logic                            i_out_pop,
    output logic                            o_d_valid,
    output logic signed [hnm_pkg::DIFF_W-1:0] o_du,
    output logic signed [hnm_pkg::DIFF_W-1:0] o_dv
);
    import hnm_pkg::*;

    logic [HEIGHT_W-1:0] mem [0:MAX_SIDE*MAX_SIDE-1];
    logic signed [HEIGHT_W-1:0] r_rdata;
    logic signed [HEIGHT_W-1:0] r_h [0:NB_COUNT-2];

    logic                            r_busy;
    logic [NB_W-1:0]                 r_phase;
    logic [NB_COUNT-1:0][ADDR_W-1:0] r_nb;
    logic                            r_tag_v;
    logic [NB_W-1:0]                 r_tag_idx;
    logic [OCNT_W-1:0]               r_credit;
    logic                            r_d_v;
    logic signed [DIFF_W-1:0]        r_du, r_dv;

    logic              pop, rd_start, wr_en, last_tag;
    logic [ADDR_W-1:0] addr;

    assign o_cmd_ready = !r_busy &&
        (i_cmd.req == REQ_STORE || r_credit < OCNT_W'(OUT_DEPTH));
    assign pop      = i_cmd_valid && o_cmd_ready;
    assign rd_start = pop && i_cmd.req == REQ_READ;
    assign wr_en    = pop && i_cmd.req == REQ_STORE;
    assign addr     = r_busy ? r_nb[r_phase] : i_cmd.addr[NB_XN];
    assign last_tag = r_tag_v && r_tag_idx == NB_YP;

    // single port tile memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[addr] <= i_cmd.height;
        end
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= '0;
            r_tag_v  <= 1'b0;
            r_credit <= '0;
            r_d_v    <= 1'b0;
        end else begin
            if (rd_start) begin
                r_busy  <= 1'b1;
                r_phase <= NB_XP;
            end else if (r_busy) begin
                r_phase <= r_phase + NB_W'(1);
                if (r_phase == NB_YP) begin
                    r_busy <= 1'b0;
                end
            end
            r_tag_v  <= rd_start || r_busy;
            r_credit <= r_credit + OCNT_W'(rd_start) - OCNT_W'(i_out_pop);
            r_d_v    <= last_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_start) begin
            r_nb <= i_cmd.addr;
        end
        r_tag_idx <= r_busy ? r_phase : NB_XN;
        if (r_tag_v && !last_tag) begin
            r_h[r_tag_idx] <= r_rdata;
        end
        if (last_tag) begin
            r_du <= DIFF_W'(r_h[NB_XN]) - DIFF_W'(r_h[NB_XP]);
            r_dv <= DIFF_W'(r_h[NB_YN]) - DIFF_W'(r_rdata);
        end
    end

    assign o_d_valid = r_d_v;
    assign o_du      = r_du;
    assign o_dv      = r_dv;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= OCNT_W'(OUT_DEPTH))
        else $error("result credit exceeded");

    a_fetch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == NB_YP) |=> r_tag_v && r_tag_idx == NB_YP ##1 r_d_v)
        else $error("neighbour fetch did not complete");

endmodule

// ===== src/hnm_math.sv =====
module hnm_math (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [hnm_pkg::DIFF_W-1:0]  i_du,
    input  logic signed [hnm_pkg::DIFF_W-1:0]  i_dv,
    input  logic [hnm_pkg::STRENGTH_W-1:0]     i_strength,
    output logic                               o_empty,
    input  logic                               i_pop,
    output hnm_pkg::t_normal                   o_normal
);
    import hnm_pkg::*;

    // gradient scale
    logic                       r1_v;
    logic signed [PROD_W-1:0]   r1_a, r1_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        r1_a <= -(PROD_W'(i_du) * PROD_W'($signed({1'b0, i_strength})));
        r1_b <= -(PROD_W'(i_dv) * PROD_W'($signed({1'b0, i_strength})));
    end

    // squares
    logic [PROD_W-1:0]       abs_a, abs_b;
    logic [MAG_W-1:0]        mag_a, mag_b;
    logic                    r2_v;
    logic [2*MAG_W-1:0]      r2_sa, r2_sb;
    logic signed [PROD_W-1:0] r2_a, r2_b;
    assign abs_a = r1_a[PROD_W-1] ? -r1_a : r1_a;
    assign abs_b = r1_b[PROD_W-1] ? -r1_b : r1_b;
    assign mag_a = abs_a[MAG_W-1:0];
    assign mag_b = abs_b[MAG_W-1:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        r2_sa <= mag_a * mag_a;
        r2_sb <= mag_b * mag_b;
        r2_a  <= r1_a;
        r2_b  <= r1_b;
    end

    // square root, one result bit per stage; stage 0 holds the radicand
    logic                     r_sv [0:ROOT_STEPS];
    logic [SQ_W-1:0]          r_sn [0:ROOT_STEPS];
    logic [SQ_W-1:0]          r_sr [0:ROOT_STEPS];
    logic signed [PROD_W-1:0] r_sa [0:ROOT_STEPS];
    logic signed [PROD_W-1:0] r_sb [0:ROOT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= r2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        r_sn[0] <= SQ_W'(r2_sa) + SQ_W'(r2_sb) + LEN_BIAS;
        r_sr[0] <= '0;
        r_sa[0] <= r2_a;
        r_sb[0] <= r2_b;
    end

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
        logic [SQ_W-1:0] trial;
        assign trial = r_sr[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (r_sn[k] >= trial) begin
                r_sn[k+1] <= r_sn[k] - trial;
                r_sr[k+1] <= (r_sr[k] >> 1) + BIT;
            end else begin
                r_sn[k+1] <= r_sn[k];
                r_sr[k+1] <= r_sr[k] >> 1;
            end
            r_sa[k+1] <= r_sa[k];
            r_sb[k+1] <= r_sb[k];
        end
    end

    // numerators: floor((510*(c+L) + 2L) / 4) per component
    logic [ROOT_W-1:0]        len;
    logic signed [PROD_W-1:0] comp [0:2];
    logic signed [PROD_W:0]   tsum [0:2];
    logic [NUM_W-1:0]         tval [0:2];
    logic [NUM_W-1:0]         num  [0:2];

    assign len     = r_sr[ROOT_STEPS][ROOT_W-1:0];
    assign comp[0] = r_sa[ROOT_STEPS];
    assign comp[1] = r_sb[ROOT_STEPS];
    assign comp[2] = ONE_Q22;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tsum[i] = (PROD_W+1)'(comp[i]) + (PROD_W+1)'($signed({1'b0, len}));
            tval[i] = NUM_W'($unsigned(tsum[i]));
            num[i]  = (tval[i] << 9) - (tval[i] << 1) + (NUM_W'(len) << 1);
        end
    end

    // restoring division by L, one quotient bit per stage
    logic              r_dv [0:Q_STEPS];
    logic [ROOT_W-1:0] r_dl [0:Q_STEPS];
    logic [NUM_W-1:0]  r_dr [0:Q_STEPS][0:2];
    logic [Q_W-1:0]    r_dq [0:Q_STEPS][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_sv[ROOT_STEPS];
        end
    end
    always_ff @(posedge i_clk) begin
        r_dl[0] <= len;
        for (int i = 0; i < 3; i++) begin
            r_dr[0][i] <= num[i] >> 2;
            r_dq[0][i] <= '0;
        end
    end

    for (genvar j = 0; j < Q_STEPS; j++) begin : g_div
        localparam int SH = Q_STEPS - 1 - j;
        logic [NUM_W-1:0] dsub;
        assign dsub = NUM_W'(r_dl[j]) << SH;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end
        always_ff @(posedge i_clk) begin
            r_dl[j+1] <= r_dl[j];
            for (int i = 0; i < 3; i++) begin
                if (r_dr[j][i] >= dsub) begin
                    r_dr[j+1][i] <= r_dr[j][i] - dsub;
                    r_dq[j+1][i] <= r_dq[j][i] | (Q_W'(1) << SH);
                end else begin
                    r_dr[j+1][i] <= r_dr[j][i];
                    r_dq[j+1][i] <= r_dq[j][i];
                end
            end
        end
    end

    logic [CODE_W-1:0] code [0:2];
    t_normal           res;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            code[i] = (r_dq[Q_STEPS][i] > CODE_MAX) ? CODE_MAX[CODE_W-1:0]
                                                    : r_dq[Q_STEPS][i][CODE_W-1:0];
        end
        res.x = code[0];
        res.y = code[1];
        res.z = code[2];
    end

    // result queue
    t_normal           r_out [0:OUT_DEPTH-1];
    logic [OPTR_W-1:0] r_owr, r_ord;
    logic [OCNT_W-1:0] r_ocnt;
    logic              push_en, pop_en;

    assign push_en  = r_dv[Q_STEPS];
    assign o_empty  = r_ocnt == '0;
    assign pop_en   = i_pop && !o_empty;
    assign o_normal = r_out[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (push_en) begin
                r_owr <= r_owr + OPTR_W'(1);
            end
            if (pop_en) begin
                r_ord <= r_ord + OPTR_W'(1);
            end
            r_ocnt <= r_ocnt + OCNT_W'(push_en) - OCNT_W'(pop_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_out[r_owr] <= res;
        end
    end

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en |-> r_ocnt < OCNT_W'(OUT_DEPTH) || pop_en)
        else $error("result queue overflow");

endmodule

// ===== tb/height_to_normal_map_tb.sv =====
module height_to_normal_map_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hnm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int DRAIN_CYCLES = 64;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic                    i_req_type;
    logic [COORD_W-1:0]      i_texel_x;
    logic [COORD_W-1:0]      i_texel_y;
    logic signed [HEIGHT_W-1:0] i_height_sample;
    logic                    empty;
    logic                    pop;
    logic [CODE_W-1:0]       o_normal_x_code;
    logic [CODE_W-1:0]       o_normal_y_code;
    logic [CODE_W-1:0]       o_normal_z_code;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    height_to_normal_map u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_req_type      (i_req_type),
        .i_texel_x       (i_texel_x),
        .i_texel_y       (i_texel_y),
        .i_height_sample (i_height_sample),
        .empty           (empty),
        .pop             (pop),
        .o_normal_x_code (o_normal_x_code),
        .o_normal_y_code (o_normal_y_code),
        .o_normal_z_code (o_normal_z_code),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // mirror of the tile and registers
    logic [HEIGHT_W-1:0]   tile_mem [MAX_SIDE*MAX_SIDE];
    bit                    tile_written [MAX_SIDE*MAX_SIDE];
    logic [SIDE_W-1:0]     side_reg;
    logic [STRENGTH_W-1:0] strength_reg;

    t_normal expected_normals[$];
    int      mismatches;
    bit      tx_gaps_on;
    bit      rx_gaps_on;
    int      rx_hold_left;
    int      rx_gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("height_to_normal_map_tb: done, errors");
        $finish;
    end

    function automatic int unsigned active_side();
        int unsigned s;
        s = side_reg;
        if (s < 2) s = 2;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s;
    endfunction

    function automatic int unsigned clip_coord(logic [COORD_W-1:0] c);
        return (c > active_side() - 1) ? active_side() - 1 : int'(c);
    endfunction

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] unorm_code(longint c, longint len);
        longint num;
        longint code;
        num = 510 * (c + len) + 2 * len;
        if (num < 0) num = 0;
        code = num / (4 * len);
        return (code > 255) ? 8'd255 : CODE_W'(code);
    endfunction

    function automatic longint height_at(int unsigned x, int unsigned y);
        return longint'($signed(tile_mem[y*MAX_SIDE + x]));
    endfunction

    function automatic t_normal normal_at(int unsigned x, int unsigned y);
        int unsigned last;
        int unsigned xp, xn, yp, yn;
        longint du, dv, a, b, len;
        longint unsigned mag2;
        t_normal n;
        last = active_side() - 1;
        xp = (x == 0) ? last : x - 1;
        xn = (x == last) ? 0 : x + 1;
        yp = (y == 0) ? last : y - 1;
        yn = (y == last) ? 0 : y + 1;
        du = height_at(xn, y) - height_at(xp, y);
        dv = height_at(x, yn) - height_at(x, yp);
        a = -du * longint'(strength_reg);
        b = -dv * longint'(strength_reg);
        mag2 = longint'(a * a) + longint'(b * b) + (64'd1 << 44);
        len = longint'(int_root(mag2));
        n.x = unorm_code(a, len);
        n.y = unorm_code(b, len);
        n.z = unorm_code(longint'(ONE_Q22), len);
        return n;
    endfunction

    function automatic logic [HEIGHT_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h4000;
            3: return 16'hC000;
            default: return HEIGHT_W'($urandom);
        endcase
    endfunction

    // entered and left at a falling edge; push stays high on return
    task automatic send_req(t_req r, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [HEIGHT_W-1:0] h);
        int gap;
        int unsigned sx, sy;
        gap = 0;
        if (tx_gaps_on) begin
            if ($urandom_range(0, 14) == 0) gap = $urandom_range(10, 40);
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_req_type = r;
        i_texel_x = x;
        i_texel_y = y;
        i_height_sample = h;
        do @(posedge i_clk); while (full);
        sx = clip_coord(x);
        sy = clip_coord(y);
        if (r == REQ_STORE) begin
            tile_mem[sy*MAX_SIDE + sx] = h;
            tile_written[sy*MAX_SIDE + sx] = 1'b1;
        end else begin
            expected_normals.push_back(normal_at(sx, sy));
        end
        @(negedge i_clk);
    endtask

    task automatic store_if_blank(int unsigned x, int unsigned y);
        if (!tile_written[y*MAX_SIDE + x])
            send_req(REQ_STORE, COORD_W'(x), COORD_W'(y), pick_height());
    endtask

    // fills any unwritten neighbour first, then reads
    task automatic read_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        int unsigned sx, sy, last;
        sx = clip_coord(x);
        sy = clip_coord(y);
        last = active_side() - 1;
        store_if_blank((sx == last) ? 0 : sx + 1, sy);
        store_if_blank((sx == 0) ? last : sx - 1, sy);
        store_if_blank(sx, (sy == last) ? 0 : sy + 1);
        store_if_blank(sx, (sy == 0) ? last : sy - 1);
        send_req(REQ_READ, x, y, HEIGHT_W'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        push = 1'b0;
        while (expected_normals.size() != 0) @(negedge i_clk);
        // stores produce nothing, so allow the pipe to settle
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TILE_SIDE) side_reg = data[SIDE_W-1:0];
        else if (idx == CFG_BUMP_STRENGTH) strength_reg = data[STRENGTH_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_items(int count);
        logic [COORD_W-1:0] x, y;
        int unsigned lim;
        repeat (count) begin
            lim = ($urandom_range(0, 7) == 0) ? MAX_SIDE - 1 : active_side() - 1;
            x = COORD_W'($urandom_range(0, lim));
            y = COORD_W'($urandom_range(0, lim));
            if ($urandom_range(0, 1) == 0) read_at(x, y);
            else send_req(REQ_STORE, x, y, pick_height());
        end
    endtask

    task automatic test_reset_config();
        // untouched registers: full tile, default strength; flat area reads (128,128,255)
        send_req(REQ_STORE, 6'd1, 6'd0, 16'h0000);
        send_req(REQ_STORE, 6'd63, 6'd0, 16'h0000);
        send_req(REQ_STORE, 6'd0, 6'd1, 16'h0000);
        send_req(REQ_STORE, 6'd0, 6'd63, 16'h0000);
        send_req(REQ_READ, 6'd0, 6'd0, 16'h0000);
        read_at(6'd63, 6'd63);
        read_at(6'd21, 6'd42);
    endtask

    task automatic test_small_tile_extremes();
        write_reg(CFG_TILE_SIDE, 12'd2);
        write_reg(CFG_BUMP_STRENGTH, 12'hFFF);
        send_req(REQ_STORE, 6'd0, 6'd0, 16'h7FFF);
        send_req(REQ_STORE, 6'd1, 6'd0, 16'h8000);
        send_req(REQ_STORE, 6'd0, 6'd1, 16'h8000);
        // coordinates past the edge clip to the last texel
        send_req(REQ_STORE, 6'd63, 6'd63, 16'h7FFF);
        send_req(REQ_READ, 6'd0, 6'd0, 16'h0000);
        send_req(REQ_READ, 6'd1, 6'd0, 16'hFFFF);
        send_req(REQ_READ, 6'd0, 6'd1, 16'h0000);
        send_req(REQ_READ, 6'd63, 6'd63, 16'hFFFF);
        send_req(REQ_STORE, 6'd1, 6'd63, 16'h4000);
        send_req(REQ_STORE, 6'd63, 6'd0, 16'hC000);
        send_req(REQ_READ, 6'd42, 6'd21, 16'h0000);
        send_req(REQ_READ, 6'd0, 6'd0, 16'h0000);
        write_reg(CFG_BUMP_STRENGTH, 12'd0);
        send_req(REQ_READ, 6'd1, 6'd1, 16'h0000);
        send_req(REQ_READ, 6'd0, 6'd0, 16'h0000);
    endtask

    task automatic test_side_clamping();
        // below two acts as two, above the maximum acts as the maximum
        write_reg(CFG_BUMP_STRENGTH, 12'd256);
        write_reg(CFG_TILE_SIDE, 12'd0);
        read_at(6'd1, 6'd0);
        write_reg(CFG_TILE_SIDE, 12'hF81);
        read_at(6'd63, 6'd5);
        write_reg(CFG_TILE_SIDE, 12'd127);
        read_at(6'd63, 6'd0);
        write_reg(CFG_TILE_SIDE, 12'd65);
        read_at(6'd0, 6'd63);
        // spare indexes change nothing
        write_reg(CFG_SPARE_A, 12'hFFF);
        write_reg(CFG_SPARE_B, 12'd1);
        read_at(6'd0, 6'd63);
    endtask

    task automatic test_random_sweep();
        logic [CFG_DATA_W-1:0] sides [6];
        logic [CFG_DATA_W-1:0] strengths [6];
        sides = '{12'd3, 12'd5, 12'd8, 12'd17, 12'd2, 12'd64};
        strengths = '{12'hFFF, 12'd1536, 12'd0, 12'd77, 12'd2048, 12'd1};
        for (int i = 0; i < 6; i++) begin
            write_reg(CFG_TILE_SIDE, sides[i] | CFG_DATA_W'($urandom_range(0, 31) << 7));
            write_reg(CFG_BUMP_STRENGTH, (i == 5) ? CFG_DATA_W'($urandom) : strengths[i]);
            tx_gaps_on = (i != 2);
            rx_gaps_on = (i != 3);
            random_items(150);
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_output_stall();
        write_reg(CFG_TILE_SIDE, 12'd4);
        write_reg(CFG_BUMP_STRENGTH, 12'd900);
        for (int i = 0; i < 16; i++) begin
            send_req(REQ_STORE, COORD_W'(i % 4), COORD_W'(i / 4), pick_height());
        end
        tx_gaps_on = 1'b0;
        rx_hold_left = 600;
        for (int i = 0; i < 40; i++) read_at(COORD_W'($urandom), COORD_W'($urandom));
        tx_gaps_on = 1'b1;
        random_items(150);
    endtask

    // receiver: random pops, with a long hold-off on request
    initial begin
        pop = 1'b0;
        rx_hold_left = 0;
        rx_gap_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                pop = 1'b0;
                rx_hold_left--;
            end else if (rx_gaps_on && rx_gap_left > 0) begin
                pop = 1'b0;
                rx_gap_left--;
            end else begin
                pop = 1'b1;
                if (rx_gaps_on) begin
                    if ($urandom_range(0, 14) == 0) rx_gap_left = $urandom_range(10, 40);
                    else if ($urandom_range(0, 2) == 0) rx_gap_left = $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_normal exp_n;
        if (i_rst_n && pop && !empty) begin
            if (expected_normals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal %0d %0d %0d", o_normal_x_code,
                             o_normal_y_code, o_normal_z_code);
            end else begin
                exp_n = expected_normals.pop_front();
                if (o_normal_x_code !== exp_n.x || o_normal_y_code !== exp_n.y ||
                    o_normal_z_code !== exp_n.z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("normal mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 exp_n.x, exp_n.y, exp_n.z, o_normal_x_code,
                                 o_normal_y_code, o_normal_z_code);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        side_reg = SIDE_RESET;
        strength_reg = STRENGTH_RESET;
        foreach (tile_written[i]) tile_written[i] = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_req_type = REQ_STORE;
        i_texel_x = '0;
        i_texel_y = '0;
        i_height_sample = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TILE_SIDE;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_config();
        test_small_tile_extremes();
        test_side_clamping();
        test_random_sweep();
        test_output_stall();

        push = 1'b0;
        while (expected_normals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_normals.size() == 0) begin
            $display("height_to_normal_map_tb: done, clean");
        end else begin
            $display("height_to_normal_map_tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/hnm_pkg.sv
src/hnm_front.sv
src/hnm_cmd_queue.sv
src/hnm_back.sv
src/hnm_math.sv
src/height_to_normal_map.sv
tb/height_to_normal_map_tb.sv
